FILE: rtl/point_segment_distance_assert.svh
// assertion helpers for the point to segment distance block
`ifndef POINT_SEGMENT_DISTANCE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_ASSERT_SVH

// clocked assertion, masked while reset is held
`define PSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/psd_pkg.sv
`timescale 1ns / 1ps
package psd_pkg;

  // where the projection landed on the segment
  typedef enum logic [1:0] {
    CLAMP_NONE   = 2'd0,
    CLAMP_FIRST  = 2'd1,
    CLAMP_SECOND = 2'd2
  } clamp_e;

  // pipeline control shared by every stage
  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

  // per item flags decided after the dot products
  typedef struct packed {
    clamp_e kind;
    logic   degen;
    logic   neg_x;
    logic   neg_y;
  } seg_flags_t;

  localparam int FlagBits = $bits(seg_flags_t);

endpackage

FILE: rtl/psd_proj.sv
`timescale 1ns / 1ps
module psd_proj #(
  parameter int CW = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  psd_pkg::pipe_ctl_t      ctl_i,
  input  logic signed [CW-1:0]    qx_i,
  input  logic signed [CW-1:0]    qy_i,
  input  logic signed [CW-1:0]    ax_i,
  input  logic signed [CW-1:0]    ay_i,
  input  logic signed [CW-1:0]    bx_i,
  input  logic signed [CW-1:0]    by_i,
  output logic                    vld_o,
  output logic [2*CW:0]           num_o,
  output logic [2*CW+1:0]         den_o,
  output logic [CW:0]             mdx_o,
  output logic [CW:0]             mdy_o,
  output psd_pkg::seg_flags_t     flags_o,
  output logic signed [CW-1:0]    base_x_o,
  output logic signed [CW-1:0]    base_y_o,
  output logic signed [CW-1:0]    qx_o,
  output logic signed [CW-1:0]    qy_o
);
  import psd_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int NW = 2 * CW + 3;

  // stage 1: edge and offset vectors
  logic                 v1_q;
  logic signed [DW-1:0] dx_q, dy_q, ex_q, ey_q;
  logic signed [CW-1:0] ax1_q, ay1_q, bx1_q, by1_q, qx1_q, qy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ctl_i.adv) begin
      v1_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      dx_q  <= DW'(bx_i) - DW'(ax_i);
      dy_q  <= DW'(by_i) - DW'(ay_i);
      ex_q  <= DW'(qx_i) - DW'(ax_i);
      ey_q  <= DW'(qy_i) - DW'(ay_i);
      ax1_q <= ax_i;
      ay1_q <= ay_i;
      bx1_q <= bx_i;
      by1_q <= by_i;
      qx1_q <= qx_i;
      qy1_q <= qy_i;
    end
  end

  // stage 2: products and edge magnitudes
  logic                 v2_q;
  logic signed [PW-1:0] pex_q, pey_q, sxx_q, syy_q;
  logic [DW-1:0]        mdx_q, mdy_q;
  logic                 ngx_q, ngy_q;
  logic signed [CW-1:0] ax2_q, ay2_q, bx2_q, by2_q, qx2_q, qy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ctl_i.adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      pex_q <= ex_q * dx_q;
      pey_q <= ey_q * dy_q;
      sxx_q <= dx_q * dx_q;
      syy_q <= dy_q * dy_q;
      mdx_q <= dx_q[DW-1] ? $unsigned(-dx_q) : $unsigned(dx_q);
      mdy_q <= dy_q[DW-1] ? $unsigned(-dy_q) : $unsigned(dy_q);
      ngx_q <= dx_q[DW-1];
      ngy_q <= dy_q[DW-1];
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      bx2_q <= bx1_q;
      by2_q <= by1_q;
      qx2_q <= qx1_q;
      qy2_q <= qy1_q;
    end
  end

  // stage 3: dot product, squared length and clamp decision
  logic signed [NW-1:0] num_d;
  logic [PW-1:0]        den_d;
  seg_flags_t           flags_d;

  always_comb begin
    num_d         = NW'(pex_q) + NW'(pey_q);
    den_d         = $unsigned(sxx_q) + $unsigned(syy_q);
    flags_d.degen = (den_d == '0);
    flags_d.neg_x = ngx_q;
    flags_d.neg_y = ngy_q;
    if (num_d[NW-1] || (num_d == '0)) begin
      flags_d.kind = CLAMP_FIRST;
    end else if (num_d[PW-1:0] >= den_d) begin
      flags_d.kind = CLAMP_SECOND;
    end else begin
      flags_d.kind = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      num_o    <= num_d[2*CW:0];
      den_o    <= den_d;
      mdx_o    <= mdx_q;
      mdy_o    <= mdy_q;
      flags_o  <= flags_d;
      base_x_o <= (flags_d.kind == CLAMP_SECOND) ? bx2_q : ax2_q;
      base_y_o <= (flags_d.kind == CLAMP_SECOND) ? by2_q : ay2_q;
      qx_o     <= qx2_q;
      qy_o     <= qy2_q;
    end
  end

endmodule

FILE: rtl/psd_div.sv
`timescale 1ns / 1ps
module psd_div #(
  parameter int CW    = 16,
  parameter int TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  psd_pkg::pipe_ctl_t ctl_i,
  input  logic [2*CW:0]    num_i,
  input  logic [2*CW+1:0]  den_i,
  input  logic [CW:0]      mdx_i,
  input  logic [CW:0]      mdy_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             vld_o,
  output logic [CW:0]      qx_o,
  output logic [CW:0]      qy_o,
  output logic [TAG_W-1:0] tag_o
);
  import psd_pkg::*;

  localparam int HW   = CW + 1;          // low half of num
  localparam int QW   = CW + 1;          // quotient bits
  localparam int PRW  = 3 * CW + 2;      // |d| * num
  localparam int NW   = 3 * CW + 3;      // dividend
  localparam int DVW  = 2 * CW + 3;      // divisor
  localparam int DENW = 2 * CW + 2;

  // stage a: partial products of |d| by the two halves of num
  logic              va_q;
  logic [2*HW-1:0]   plx_q, ply_q;
  logic [2*CW:0]     phx_q, phy_q;
  logic [DENW-1:0]   dena_q;
  logic [TAG_W-1:0]  taga_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (ctl_i.adv) begin
      va_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      plx_q  <= mdx_i * num_i[HW-1:0];
      ply_q  <= mdy_i * num_i[HW-1:0];
      phx_q  <= mdx_i * num_i[2*CW:HW];
      phy_q  <= mdy_i * num_i[2*CW:HW];
      dena_q <= den_i;
      taga_q <= tag_i;
    end
  end

  // stage b: rounded dividend 2*prod + den over divisor 2*den
  logic [PRW-1:0] prx_d, pry_d;

  always_comb begin
    prx_d = PRW'(plx_q) + (PRW'(phx_q) << HW);
    pry_d = PRW'(ply_q) + (PRW'(phy_q) << HW);
  end

  logic             vs_q   [QW+1];
  logic [NW-1:0]    rx_q   [QW+1];
  logic [NW-1:0]    ry_q   [QW+1];
  logic [DVW-1:0]   dv_q   [QW+1];
  logic [QW-1:0]    qux_q  [QW+1];
  logic [QW-1:0]    quy_q  [QW+1];
  logic [TAG_W-1:0] tags_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else if (ctl_i.adv) begin
      vs_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      rx_q[0]   <= {prx_d, 1'b0} + NW'(dena_q);
      ry_q[0]   <= {pry_d, 1'b0} + NW'(dena_q);
      dv_q[0]   <= {dena_q, 1'b0};
      qux_q[0]  <= '0;
      quy_q[0]  <= '0;
      tags_q[0] <= taga_q;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BI = QW - 1 - k;
    logic [NW-1:0] trial;
    logic          takex, takey;

    always_comb begin
      trial = NW'(dv_q[k]) << BI;
      takex = (rx_q[k] >= trial);
      takey = (ry_q[k] >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else if (ctl_i.adv) begin
        vs_q[k+1] <= vs_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        rx_q[k+1]   <= takex ? (rx_q[k] - trial) : rx_q[k];
        ry_q[k+1]   <= takey ? (ry_q[k] - trial) : ry_q[k];
        dv_q[k+1]   <= dv_q[k];
        qux_q[k+1]  <= qux_q[k] | (QW'(takex) << BI);
        quy_q[k+1]  <= quy_q[k] | (QW'(takey) << BI);
        tags_q[k+1] <= tags_q[k];
      end
    end
  end

  assign vld_o = vs_q[QW];
  assign qx_o  = qux_q[QW];
  assign qy_o  = quy_q[QW];
  assign tag_o = tags_q[QW];

endmodule

FILE: rtl/psd_isqrt.sv
`timescale 1ns / 1ps
module psd_isqrt #(
  parameter int CW    = 16,
  parameter int TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  psd_pkg::pipe_ctl_t ctl_i,
  input  logic [2*CW:0]    sq_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             vld_o,
  output logic [CW:0]      root_o,
  output logic [TAG_W-1:0] tag_o
);
  import psd_pkg::*;

  localparam int RW = CW + 1;
  localparam int SW = 2 * CW + 1;
  localparam int TW = 2 * CW + 3;

  logic             v_q   [RW+1];
  logic [SW-1:0]    rem_q [RW+1];
  logic [RW-1:0]    rt_q  [RW+1];
  logic [TAG_W-1:0] tg_q  [RW+1];

  always_comb begin
    v_q[0]   = ctl_i.vld;
    rem_q[0] = sq_i;
    rt_q[0]  = '0;
    tg_q[0]  = tag_i;
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < RW; k++) begin : g_bit
    localparam int BI = RW - 1 - k;
    logic [TW-1:0] trial;
    logic          take;

    always_comb begin
      trial = (TW'(rt_q[k]) << (BI + 1)) | (TW'(1) << (2 * BI));
      take  = (TW'(rem_q[k]) >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (ctl_i.adv) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        rem_q[k+1] <= take ? SW'(TW'(rem_q[k]) - trial) : rem_q[k];
        rt_q[k+1]  <= rt_q[k] | (RW'(take) << BI);
        tg_q[k+1]  <= tg_q[k];
      end
    end
  end

  assign vld_o  = v_q[RW];
  assign root_o = rt_q[RW];
  assign tag_o  = tg_q[RW];

endmodule

FILE: rtl/point_segment_distance.sv
`timescale 1ns / 1ps
// throughput: one beat per cycle while no result is held; one divider stage per quotient bit and one
//   square root stage per root bit keep every stage at one item
// a held result stalls the whole pipeline together, nothing is dropped
// reset clears every stage valid bit; no clearing pass
module point_segment_distance #(
  parameter  int COORD_BITS = 16,
  localparam int IN_W  = ((6 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // query_x, query_y, first_x, first_y, second_x, second_y, zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // near_x, near_y, distance, zero pad
  output logic [OUT_W-1:0] m_axis_tdata,
  // clamp_kind [1:0], degenerate [2]
  output logic [2:0]       m_axis_tuser
);
  import psd_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int DTAG  = FlagBits + 4 * CW;
  localparam int STAG  = 3 + 2 * CW;

  // global advance: everything moves unless a result is held
  logic      adv;
  pipe_ctl_t in_ctl, mid_ctl, sq_ctl;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_ctl        = '{adv: adv, vld: s_axis_tvalid};

  // projection front end
  logic                 pv;
  logic [2*CW:0]        pnum;
  logic [2*CW+1:0]      pden;
  logic [CW:0]          pmdx, pmdy;
  seg_flags_t           pflags;
  logic signed [CW-1:0] pbx, pby, pqx, pqy;

  psd_proj #(.CW(CW)) u_proj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (in_ctl),
    .qx_i     (s_axis_tdata[0*CW +: CW]),
    .qy_i     (s_axis_tdata[1*CW +: CW]),
    .ax_i     (s_axis_tdata[2*CW +: CW]),
    .ay_i     (s_axis_tdata[3*CW +: CW]),
    .bx_i     (s_axis_tdata[4*CW +: CW]),
    .by_i     (s_axis_tdata[5*CW +: CW]),
    .vld_o    (pv),
    .num_o    (pnum),
    .den_o    (pden),
    .mdx_o    (pmdx),
    .mdy_o    (pmdy),
    .flags_o  (pflags),
    .base_x_o (pbx),
    .base_y_o (pby),
    .qx_o     (pqx),
    .qy_o     (pqy)
  );

  // interior offset division
  logic            dv;
  logic [CW:0]     dqx, dqy;
  logic [DTAG-1:0] dtag;

  assign mid_ctl = '{adv: adv, vld: pv};

  psd_div #(.CW(CW), .TAG_W(DTAG)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mid_ctl),
    .num_i  (pnum),
    .den_i  (pden),
    .mdx_i  (pmdx),
    .mdy_i  (pmdy),
    .tag_i  ({pflags, pbx, pby, pqx, pqy}),
    .vld_o  (dv),
    .qx_o   (dqx),
    .qy_o   (dqy),
    .tag_o  (dtag)
  );

  seg_flags_t           dflags;
  logic signed [CW-1:0] dbx, dby, dpx, dpy;

  assign {dflags, dbx, dby, dpx, dpy} = dtag;

  // nearest point: base plus signed rounded offset when interior
  logic signed [CW+1:0] offx, offy, nfx, nfy;

  always_comb begin
    offx = $signed({1'b0, dqx});
    offy = $signed({1'b0, dqy});
    if (dflags.neg_x) begin
      offx = -offx;
    end
    if (dflags.neg_y) begin
      offy = -offy;
    end
    nfx = (CW+2)'(dbx) + offx;
    nfy = (CW+2)'(dby) + offy;
  end

  logic                 nv_q;
  logic signed [CW-1:0] nx_q, ny_q, nqx_q, nqy_q;
  seg_flags_t           nflags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (adv) begin
      nv_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q     <= (dflags.kind == CLAMP_NONE) ? nfx[CW-1:0] : dbx;
      ny_q     <= (dflags.kind == CLAMP_NONE) ? nfy[CW-1:0] : dby;
      nqx_q    <= dpx;
      nqy_q    <= dpy;
      nflags_q <= dflags;
    end
  end

  // residual magnitudes
  logic signed [CW:0] rdx, rdy;

  always_comb begin
    rdx = (CW+1)'(nqx_q) - (CW+1)'(nx_q);
    rdy = (CW+1)'(nqy_q) - (CW+1)'(ny_q);
  end

  logic                 rv_q;
  logic [CW-1:0]        rmx_q, rmy_q;
  logic signed [CW-1:0] rnx_q, rny_q;
  seg_flags_t           rflags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (adv) begin
      rv_q <= nv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rmx_q    <= rdx[CW] ? CW'(-rdx) : rdx[CW-1:0];
      rmy_q    <= rdy[CW] ? CW'(-rdy) : rdy[CW-1:0];
      rnx_q    <= nx_q;
      rny_q    <= ny_q;
      rflags_q <= nflags_q;
    end
  end

  // squares
  logic                 mv_q;
  logic [2*CW-1:0]      smx_q, smy_q;
  logic signed [CW-1:0] mnx_q, mny_q;
  seg_flags_t           mflags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (adv) begin
      mv_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smx_q    <= rmx_q * rmx_q;
      smy_q    <= rmy_q * rmy_q;
      mnx_q    <= rnx_q;
      mny_q    <= rny_q;
      mflags_q <= rflags_q;
    end
  end

  // squared distance
  logic                 sv_q;
  logic [2*CW:0]        sq_q;
  logic signed [CW-1:0] snx_q, sny_q;
  seg_flags_t           sflags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else if (adv) begin
      sv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q     <= (2*CW+1)'(smx_q) + (2*CW+1)'(smy_q);
      snx_q    <= mnx_q;
      sny_q    <= mny_q;
      sflags_q <= mflags_q;
    end
  end

  // square root; its last stage is the output register
  logic            ov;
  logic [CW:0]     root;
  logic [STAG-1:0] otag;
  logic [1:0]      okind;
  logic            odegen;
  logic [CW-1:0]   onx, ony;

  assign sq_ctl = '{adv: adv, vld: sv_q};

  psd_isqrt #(.CW(CW), .TAG_W(STAG)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .sq_i   (sq_q),
    .tag_i  ({sflags_q.kind, sflags_q.degen, snx_q, sny_q}),
    .vld_o  (ov),
    .root_o (root),
    .tag_o  (otag)
  );

  assign {okind, odegen, onx, ony} = otag;

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = OUT_W'({root, ony, onx});
  assign m_axis_tuser  = {odegen, okind};

endmodule

FILE: rtl/psd_checker.sv
`timescale 1ns / 1ps
`include "point_segment_distance_assert.svh"
module psd_checker #(
  parameter int OUT_W = 56
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [2:0]       m_axis_tuser
);
  import psd_pkg::*;

  // a held result keeps its beat
  `PSD_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "held result changed")

  // input is taken whenever the output side drains
  `PSD_ASSERT(a_ready, clk_i, rst_ni, m_axis_tready |-> s_axis_tready, "input stalled with output ready")

  // a zero-length segment always reports the first endpoint clamp
  `PSD_ASSERT(a_degen, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == CLAMP_FIRST, "degenerate without first clamp")

  // reset empties the pipeline
  `PSD_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |=> !m_axis_tvalid, "valid result during reset")

endmodule

bind point_segment_distance psd_checker #(.OUT_W(OUT_W)) u_psd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
